// File: hdl/lca_pkg.sv
package lca_pkg;

    localparam int unsigned CHANNELS    = 4;
    localparam int unsigned NUM_CLASSES = 4;
    localparam int unsigned KINDS       = 4;
    localparam int unsigned CH_W        = 2;
    localparam int unsigned PH_W        = 2;
    localparam int unsigned COL_W       = CH_W + PH_W;
    localparam int unsigned CLS_W       = 2;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SCORE_W     = 64;
    localparam int unsigned IN_TDATA_W  = 168;
    localparam int unsigned OUT_TDATA_W = 264;

    localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(KINDS - 1);

    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [SCORE_W-1:0] score_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_REST,
        CLS_NEXT,
        CLS_CONFIRM,
        CLS_ABORT
    } cls_t;

    typedef enum logic {
        CMD_FEATURE = 1'b0,
        CMD_WEIGHT  = 1'b1
    } cmd_t;

    // control that rides alongside each product through a lane
    typedef struct packed {
        logic valid;
        logic load;
        logic done;
    } lca_ctl_t;

endpackage

// File: hdl/lca_seq.sv
module lca_seq
    import lca_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  cmd_t             in_cmd,
    input  logic [CH_W-1:0]  in_channel,
    input  word_t            in_feat [KINDS],
    output logic             in_ready,
    output lca_ctl_t         issue,
    output logic [COL_W-1:0] rd_addr,
    output word_t            feat
);

    logic            busy_reg, busy_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    logic            first_reg, last_reg;
    logic [CH_W-1:0] chan_reg;
    word_t           feat_reg [KINDS];
    logic            chan_ok;
    logic            take;

    assign in_ready = adv && (!busy_reg || phase_reg == LAST_PHASE);
    assign chan_ok  = 32'(in_channel) < CHANNELS;
    assign take     = in_valid && in_ready && in_cmd == CMD_FEATURE && chan_ok;

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (adv && busy_reg) begin
            if (phase_reg == LAST_PHASE) begin
                busy_next = 1'b0;
            end else begin
                phase_next = phase_reg + 1'b1;
            end
        end
        if (take) begin
            busy_next  = 1'b1;
            phase_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            chan_reg  <= in_channel;
            first_reg <= in_channel == '0;
            last_reg  <= 32'(in_channel) == CHANNELS - 1;
            feat_reg  <= in_feat;
        end
    end

    // one feature kind per cycle while adv is high, all lanes in step
    assign issue.valid = busy_reg;
    assign issue.load  = first_reg && phase_reg == '0;
    assign issue.done  = last_reg && phase_reg == LAST_PHASE;
    assign rd_addr     = {chan_reg, phase_reg};
    assign feat        = feat_reg[phase_reg];

    a_mid_item_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && phase_reg != LAST_PHASE |-> !in_ready)
        else $error("word accepted in the middle of an item");

    a_phase_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && adv && phase_reg != LAST_PHASE
        |=> busy_reg && phase_reg == $past(phase_reg) + 1'b1)
        else $error("phase did not advance");

    a_take_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> busy_reg && phase_reg == '0)
        else $error("feature word did not start at phase zero");

endmodule

// File: hdl/lca_lane.sv
module lca_lane
    import lca_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  word_t            wr_data,
    input  lca_ctl_t         issue,
    input  logic [COL_W-1:0] rd_addr,
    input  word_t            feat,
    input  word_t            intercept,
    output score_t           score,
    output logic             done
);

    word_t    mem [2**COL_W];
    word_t    wt_reg;
    word_t    feat1_reg;
    lca_ctl_t ctl1_reg, ctl2_reg;
    score_t   prod_reg;
    score_t   acc_reg, acc_next;
    logic     done_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (adv) begin
            wt_reg    <= mem[rd_addr];
            feat1_reg <= feat;
            prod_reg  <= score_t'(feat1_reg) * score_t'(wt_reg);
        end
    end

    always_comb begin
        acc_next = (ctl2_reg.load ? score_t'(intercept) : acc_reg) + prod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end else if (adv) begin
            ctl1_reg <= issue;
            ctl2_reg <= ctl1_reg;
            if (ctl2_reg.valid) begin
                acc_reg <= acc_next;
            end
            done_reg <= ctl2_reg.valid && ctl2_reg.done;
        end
    end

    assign score = acc_reg;
    assign done  = done_reg;

endmodule

// File: hdl/lca_merge.sv
module lca_merge
    import lca_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  score_t lane_score [NUM_CLASSES],
    input  logic   lane_done,
    input  logic   m_ready,
    output logic   adv,
    output logic   m_valid,
    output score_t out_score [NUM_CLASSES],
    output cls_t   out_cmd
);

    logic   a_valid_reg;
    score_t a_score_reg [NUM_CLASSES];
    logic   a_lo_reg, a_hi_reg;
    logic   out_valid_reg;
    score_t out_score_reg [NUM_CLASSES];
    cls_t   cmd_reg, cmd_next;
    score_t lo_v, hi_v;
    logic   hi_win;
    score_t win_v;

    // hold everything only when a result is ready and the output slot is still full
    assign adv = !(a_valid_reg && out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (adv && lane_done) begin
            a_score_reg <= lane_score;
            a_lo_reg    <= lane_score[1] > lane_score[0];
            a_hi_reg    <= lane_score[3] > lane_score[2];
        end
    end

    always_comb begin
        lo_v     = a_lo_reg ? a_score_reg[1] : a_score_reg[0];
        hi_v     = a_hi_reg ? a_score_reg[3] : a_score_reg[2];
        // ties stay with the lower pair
        hi_win   = hi_v > lo_v;
        cmd_next = cls_t'({hi_win, hi_win ? a_hi_reg : a_lo_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                a_valid_reg <= lane_done;
            end
            if (adv && a_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && a_valid_reg) begin
            out_score_reg <= a_score_reg;
            cmd_reg       <= cmd_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign out_score = out_score_reg;
    assign out_cmd   = cmd_reg;
    assign win_v     = out_score_reg[cmd_reg];

    a_win_is_max: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> win_v >= out_score_reg[0] && win_v >= out_score_reg[1]
                          && win_v >= out_score_reg[2] && win_v >= out_score_reg[3])
        else $error("command is not the highest score");

    a_tie_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && cmd_reg != CLS_REST |-> out_score_reg[0] < win_v)
        else $error("tie not resolved to the lower class");

    a_tie_next: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (cmd_reg == CLS_CONFIRM || cmd_reg == CLS_ABORT)
        |-> out_score_reg[1] < win_v)
        else $error("tie not resolved to the lower class");

endmodule

// File: hdl/linear_classifier_argmax.sv
// Four-class linear classifier with argmax.
// Input stream (s_*): a word with tuser 1 writes one weight into the coefficient
// store of class weight_class at column weight_feature; a word with tuser 0
// carries the four features of one channel. Channel 0 reloads the class
// accumulators from the intercepts; the last channel produces one result word
// on m_* with four 64-bit scores and the winning class (ties to the lower class).
// Intercepts are written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while the block idles, as the block itself does not enforce it. Each class
// has its own lane: a 16-entry weight memory, a 32x32 multiplier and a 64-bit
// accumulator. A feature word is issued one feature kind per cycle in every lane
// while the pipeline advances; the next is taken as its last kind issues. Weight
// words start no issue; results pass the lane, merge and output registers.
// Reset (aresetn low, synchronous) clears the intercepts, accumulators and all
// valid flags; weights are undefined until written.
// The output word sits in a register; while it waits another item is taken.
// A second finished result waiting behind it holds the whole pipeline and
// drops s_tready until m_tready frees the output.
module linear_classifier_argmax
    import lca_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // channel, weight_class, weight_feature, weight_value, mean_abs, rms_value,
    // wave_len, zero_cross
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // score_0, score_1, score_2, score_3, command, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CLS_W-1:0]       cfg_index,
    input  logic [WORD_W-1:0]      cfg_wdata
);

    word_t            intercept_reg [NUM_CLASSES];
    cmd_t             cmd;
    logic [CH_W-1:0]  channel;
    logic [CLS_W-1:0] weight_class;
    logic [COL_W-1:0] weight_feature;
    word_t            weight_value;
    word_t            in_feat [KINDS];
    logic             adv;
    logic             wr_take;
    lca_ctl_t         issue;
    logic [COL_W-1:0] rd_addr;
    word_t            feat;
    score_t           lane_score [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] lane_done;
    score_t           out_score [NUM_CLASSES];
    cls_t             out_cmd;

    assign cmd            = cmd_t'(s_tuser);
    assign channel        = s_tdata[1:0];
    assign weight_class   = s_tdata[3:2];
    assign weight_feature = s_tdata[7:4];
    assign weight_value   = s_tdata[39:8];
    assign in_feat[0]     = s_tdata[71:40];
    assign in_feat[1]     = s_tdata[103:72];
    assign in_feat[2]     = s_tdata[135:104];
    assign in_feat[3]     = s_tdata[167:136];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intercept_reg <= '{default: '0};
        end else if (cfg_we) begin
            intercept_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign wr_take = s_tvalid && s_tready && cmd == CMD_WEIGHT;

    lca_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_cmd     (cmd),
        .in_channel (channel),
        .in_feat    (in_feat),
        .in_ready   (s_tready),
        .issue      (issue),
        .rd_addr    (rd_addr),
        .feat       (feat)
    );

    for (genvar l = 0; l < NUM_CLASSES; l++) begin : g_lane
        lca_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .wr_en     (wr_take && weight_class == CLS_W'(l)),
            .wr_addr   (weight_feature),
            .wr_data   (weight_value),
            .issue     (issue),
            .rd_addr   (rd_addr),
            .feat      (feat),
            .intercept (intercept_reg[l]),
            .score     (lane_score[l]),
            .done      (lane_done[l])
        );
    end

    lca_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lane_score (lane_score),
        .lane_done  (lane_done[0]),
        .m_ready    (m_tready),
        .adv        (adv),
        .m_valid    (m_tvalid),
        .out_score  (out_score),
        .out_cmd    (out_cmd)
    );

    assign m_tdata = {6'b0, out_cmd, out_score[3], out_score[2], out_score[1], out_score[0]};

endmodule
